>>> hw/rtl/masked_moving_average_4ch_assert.svh
// Assertion macros for the RTL of the masked moving average block.
// Each macro assumes the module has i_clk and i_rst_n in scope.
`ifndef MASKED_MOVING_AVERAGE_4CH_ASSERT_SVH
`define MASKED_MOVING_AVERAGE_4CH_ASSERT_SVH

// Holds in every cycle out of reset.
`define MMA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("check failed: lbl");

// The consequent holds in the same cycle as the antecedent.
`define MMA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed: lbl");

// The consequent holds in the cycle after the antecedent.
`define MMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed: lbl");

`endif

>>> hw/rtl/mma_pkg.sv
`timescale 1ns / 1ps

package mma_pkg;

    localparam int MAX_WINDOW     = 32;
    localparam int CHANNELS       = 4;
    localparam int ADDR_W         = $clog2(MAX_WINDOW);
    localparam int LEN_W          = $clog2(MAX_WINDOW + 1);
    localparam int DATA_W         = 16;
    localparam int NARROW_W       = 14;
    localparam int SUM_W          = DATA_W + ADDR_W;
    localparam int DIV_STEPS      = SUM_W;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int REC_W          = CHANNELS * DATA_W + CHANNELS;
    localparam int DEFAULT_WINDOW = 7;

    // Control shared by all four lanes.
    typedef struct packed {
        logic clear;
        logic update;
        logic retire;
        logic div_start;
        logic div_step;
    } t_lane_ctrl;

    typedef logic [DATA_W-1:0] t_sample;

endpackage

>>> hw/rtl/masked_moving_average_4ch.sv
// An item that completes the window passes the running sum update and divider load, the
// steps of the 21-step divider and one merge before its result shows. A new item is only
// taken once the last is done: the lanes divide and the merge waits for a free output.
// Items that only fill the window are done after the running sum update.
// Reset (synchronous, active low) empties the window and sets the window length to 7.
`timescale 1ns / 1ps

module masked_moving_average_4ch
    import mma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LEN_W-1:0]    i_cfg_window_length,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [DATA_W-1:0]   i_weight_hundredths,
    input  logic                i_weight_present,
    input  logic [NARROW_W-1:0] i_fat_hundredths,
    input  logic                i_fat_present,
    input  logic [NARROW_W-1:0] i_muscle_hundredths,
    input  logic                i_muscle_present,
    input  logic [NARROW_W-1:0] i_water_hundredths,
    input  logic                i_water_present,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DATA_W-1:0]   o_weight_avg,
    output logic                o_weight_avg_ok,
    output logic [NARROW_W-1:0] o_fat_avg,
    output logic                o_fat_avg_ok,
    output logic [NARROW_W-1:0] o_muscle_avg,
    output logic                o_muscle_avg_ok,
    output logic [NARROW_W-1:0] o_water_avg,
    output logic                o_water_avg_ok
);

`include "masked_moving_average_4ch_assert.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_MERGE  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [LEN_W-1:0]     r_fill, n_fill;
    logic [ADDR_W-1:0]    r_write_slot, n_write_slot;
    logic [ADDR_W-1:0]    r_slot;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;

    t_sample              r_new_val [CHANNELS];
    logic [CHANNELS-1:0]  r_new_pres;
    t_sample              in_val  [CHANNELS];
    logic [CHANNELS-1:0]  in_pres;

    t_sample              r_out_avg [CHANNELS];
    logic [CHANNELS-1:0]  r_out_ok;
    t_sample              lane_avg  [CHANNELS];
    logic [CHANNELS-1:0]  lane_ok;

    logic                 in_fire, cfg_fire, out_fire, merge_fire;
    logic                 full_before;
    logic [ADDR_W-1:0]    cur_slot;
    logic [LEN_W-1:0]     slot_inc;
    logic [LEN_W-1:0]     fill_inc;
    logic [LEN_W-1:0]     cfg_len;
    logic [REC_W-1:0]     ring_wdata, ring_rdata;
    t_lane_ctrl           lane_ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign merge_fire  = (r_state == ST_MERGE) && (!r_out_valid || i_out_ready);

    assign in_val[0] = i_weight_hundredths;
    assign in_val[1] = DATA_W'(i_fat_hundredths);
    assign in_val[2] = DATA_W'(i_muscle_hundredths);
    assign in_val[3] = DATA_W'(i_water_hundredths);
    assign in_pres   = {i_water_present, i_muscle_present, i_fat_present, i_weight_present};

    // A write slot left beyond a shortened window restarts at the bottom of the ring.
    assign cur_slot    = ({1'b0, r_write_slot} >= r_len) ? '0 : r_write_slot;
    assign slot_inc    = {1'b0, r_slot} + LEN_W'(1);
    assign full_before = (r_fill >= r_len);
    assign fill_inc    = full_before ? r_fill : r_fill + LEN_W'(1);

    always_comb begin
        if (i_cfg_window_length == '0) begin
            cfg_len = LEN_W'(1);
        end else if (i_cfg_window_length > LEN_W'(MAX_WINDOW)) begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end else begin
            cfg_len = i_cfg_window_length;
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            ring_wdata[c*DATA_W +: DATA_W] = r_new_val[c];
        end
        ring_wdata[REC_W-1 -: CHANNELS] = r_new_pres;
    end

    mma_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_UPDATE),
        .i_waddr (r_slot),
        .i_wdata (ring_wdata),
        .i_re    (in_fire),
        .i_raddr (cur_slot),
        .o_rdata (ring_rdata)
    );

    always_comb begin
        lane_ctrl.clear     = cfg_fire;
        lane_ctrl.update    = (r_state == ST_UPDATE);
        lane_ctrl.retire    = full_before;
        lane_ctrl.div_start = (r_state == ST_UPDATE);
        lane_ctrl.div_step  = (r_state == ST_DIV);
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        mma_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (lane_ctrl),
            .i_new_val  (r_new_val[g]),
            .i_new_pres (r_new_pres[g]),
            .i_old_val  (ring_rdata[g*DATA_W +: DATA_W]),
            .i_old_pres (ring_rdata[CHANNELS*DATA_W + g]),
            .o_avg      (lane_avg[g]),
            .o_ok       (lane_ok[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_fill       = r_fill;
        n_write_slot = r_write_slot;
        n_div_cnt    = r_div_cnt;
        n_out_valid  = r_out_valid;

        if (out_fire) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_fill       = fill_inc;
                n_write_slot = (slot_inc >= r_len) ? '0 : slot_inc[ADDR_W-1:0];
                n_div_cnt    = '0;
                // The sums and counts now cover the window; the lanes divide only
                // once the window holds a full set of records.
                n_state      = (fill_inc >= r_len) ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (merge_fire) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_fire) begin
            n_len        = cfg_len;
            n_fill       = '0;
            n_write_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_len        <= LEN_W'(DEFAULT_WINDOW);
            r_fill       <= '0;
            r_write_slot <= '0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_len        <= n_len;
            r_fill       <= n_fill;
            r_write_slot <= n_write_slot;
            r_div_cnt    <= n_div_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // Missing samples are stored as zero.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_slot <= cur_slot;
            for (int c = 0; c < CHANNELS; c++) begin
                r_new_val[c] <= in_pres[c] ? in_val[c] : '0;
            end
            r_new_pres <= in_pres;
        end
    end

    // Merge stage: the four lane results land in one output record.
    always_ff @(posedge i_clk) begin
        if (merge_fire) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_out_avg[c] <= lane_avg[c];
            end
            r_out_ok <= lane_ok;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_weight_avg    = r_out_avg[0];
    assign o_weight_avg_ok = r_out_ok[0];
    assign o_fat_avg       = r_out_avg[1][NARROW_W-1:0];
    assign o_fat_avg_ok    = r_out_ok[1];
    assign o_muscle_avg    = r_out_avg[2][NARROW_W-1:0];
    assign o_muscle_avg_ok = r_out_ok[2];
    assign o_water_avg     = r_out_avg[3][NARROW_W-1:0];
    assign o_water_avg_ok  = r_out_ok[3];

    `MMA_ASSERT_ALWAYS(a_fill_within_len, r_fill <= r_len)
    `MMA_ASSERT_ALWAYS(a_len_legal, (r_len != '0) && (r_len <= LEN_W'(MAX_WINDOW)))
    `MMA_ASSERT_NEXT(a_accept_updates, in_fire && !cfg_fire, r_state == ST_UPDATE)
    `MMA_ASSERT_IMPL(a_merge_needs_full, r_state == ST_MERGE, r_fill == r_len)
    `MMA_ASSERT_NEXT(a_merge_loads_out, merge_fire, r_out_valid && (r_state == ST_IDLE))

endmodule

>>> hw/rtl/mma_ring.sv
`timescale 1ns / 1ps

module mma_ring
    import mma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [REC_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [REC_W-1:0]  o_rdata
);

    logic [REC_W-1:0] r_mem [MAX_WINDOW];
    logic [REC_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mma_lane.sv
`timescale 1ns / 1ps

module mma_lane
    import mma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_lane_ctrl  i_ctrl,
    input  t_sample     i_new_val,
    input  logic        i_new_pres,
    input  t_sample     i_old_val,
    input  logic        i_old_pres,
    output t_sample     o_avg,
    output logic        o_ok
);

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0] r_quo, n_quo;

    logic             sub_en;
    logic [LEN_W:0]   trial;

    assign sub_en = i_ctrl.retire && i_old_pres;

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (i_ctrl.clear) begin
            n_sum = '0;
            n_cnt = '0;
        end else if (i_ctrl.update) begin
            n_sum = r_sum - (sub_en ? SUM_W'(i_old_val) : '0)
                          + (i_new_pres ? SUM_W'(i_new_val) : '0);
            n_cnt = r_cnt - (sub_en ? LEN_W'(1) : '0)
                          + (i_new_pres ? LEN_W'(1) : '0);
        end
    end

    // Restoring divider, one quotient bit per step. The dividend shifts out of
    // the top of r_quo while quotient bits enter at the bottom.
    assign trial = {r_rem, r_quo[SUM_W-1]};

    // The divider starts in the same cycle as the sum update, so it loads the new sum.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_ctrl.div_start) begin
            n_rem = '0;
            n_quo = n_sum;
        end else if (i_ctrl.div_step) begin
            if (trial >= {1'b0, r_cnt}) begin
                n_rem = LEN_W'(trial - {1'b0, r_cnt});
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[LEN_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // A channel with no present sample reads as zero, not as the divider's output.
    assign o_ok  = (r_cnt != '0);
    assign o_avg = o_ok ? r_quo[DATA_W-1:0] : '0;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mma_pkg::*;

    localparam int CYCLE_LIMIT  = 150000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [3:0]             pres;
        logic [3:0][DATA_W-1:0] val;
    } t_rec;

    typedef struct packed {
        logic [3:0]             ok;
        logic [3:0][DATA_W-1:0] avg;
    } t_avg;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [LEN_W-1:0]    i_cfg_window_length;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [DATA_W-1:0]   i_weight_hundredths;
    logic                i_weight_present;
    logic [NARROW_W-1:0] i_fat_hundredths;
    logic                i_fat_present;
    logic [NARROW_W-1:0] i_muscle_hundredths;
    logic                i_muscle_present;
    logic [NARROW_W-1:0] i_water_hundredths;
    logic                i_water_present;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [DATA_W-1:0]   o_weight_avg;
    logic                o_weight_avg_ok;
    logic [NARROW_W-1:0] o_fat_avg;
    logic                o_fat_avg_ok;
    logic [NARROW_W-1:0] o_muscle_avg;
    logic                o_muscle_avg_ok;
    logic [NARROW_W-1:0] o_water_avg;
    logic                o_water_avg_ok;

    masked_moving_average_4ch dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_window_length (i_cfg_window_length),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_weight_hundredths (i_weight_hundredths),
        .i_weight_present    (i_weight_present),
        .i_fat_hundredths    (i_fat_hundredths),
        .i_fat_present       (i_fat_present),
        .i_muscle_hundredths (i_muscle_hundredths),
        .i_muscle_present    (i_muscle_present),
        .i_water_hundredths  (i_water_hundredths),
        .i_water_present     (i_water_present),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_weight_avg        (o_weight_avg),
        .o_weight_avg_ok     (o_weight_avg_ok),
        .o_fat_avg           (o_fat_avg),
        .o_fat_avg_ok        (o_fat_avg_ok),
        .o_muscle_avg        (o_muscle_avg),
        .o_muscle_avg_ok     (o_muscle_avg_ok),
        .o_water_avg         (o_water_avg),
        .o_water_avg_ok      (o_water_avg_ok)
    );

    // Predictor state: ring of stored records plus running sums and counts.
    logic [3:0][DATA_W-1:0] ring_val [MAX_WINDOW];
    logic [3:0]             ring_pres [MAX_WINDOW];
    int unsigned            run_sum [CHANNELS];
    int unsigned            run_cnt [CHANNELS];
    int unsigned            fill_level;
    int unsigned            next_slot;
    logic [LEN_W-1:0]       win_len;

    t_avg        averages_due[$];
    string       ch_name [CHANNELS] = '{"weight", "fat", "muscle", "water"};
    int          errors;
    int          items_sent;
    int          averages_seen;
    int          settings_used;
    int          cycle_count;
    int          hold_left;
    int          stall_left;
    bit          idle_on;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] chan_mask(input int c);
        return (c == 0) ? 16'hFFFF : 16'h3FFF;
    endfunction

    function automatic t_rec make_rec(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] f,
                                      input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] a,
                                      input logic [3:0] p);
        t_rec r;
        r.val[0] = w;
        r.val[1] = f & chan_mask(1);
        r.val[2] = m & chan_mask(2);
        r.val[3] = a & chan_mask(3);
        r.pres   = p;
        return r;
    endfunction

    function automatic t_rec rand_rec(input int present_pct);
        t_rec        r;
        int unsigned pick;
        for (int c = 0; c < CHANNELS; c++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                r.val[c] = '0;
            else if (pick == 1)
                r.val[c] = chan_mask(c);
            else if (c == 0 || pick == 2)
                r.val[c] = DATA_W'($urandom) & chan_mask(c);
            else
                r.val[c] = DATA_W'($urandom_range(0, 10000));
            r.pres[c] = ($urandom_range(0, 99) < present_pct);
        end
        return r;
    endfunction

    function automatic int unsigned active_length();
        if (win_len == 0)
            return 1;
        if (win_len > MAX_WINDOW)
            return MAX_WINDOW;
        return win_len;
    endfunction

    // Moves one record into the window; yields the averages when the window is full.
    task automatic slide_window(input t_rec r, output bit emits, output t_avg res);
        int unsigned len;
        logic [DATA_W-1:0] v;
        len = active_length();
        if (next_slot >= len)
            next_slot = 0;
        if (fill_level >= len) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (ring_pres[next_slot][c]) begin
                    run_sum[c] -= ring_val[next_slot][c];
                    run_cnt[c] -= 1;
                end
            end
        end
        ring_pres[next_slot] = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            v = r.val[c] & chan_mask(c);
            if (r.pres[c]) begin
                ring_val[next_slot][c]  = v;
                ring_pres[next_slot][c] = 1'b1;
                run_sum[c] += v;
                run_cnt[c] += 1;
            end else begin
                ring_val[next_slot][c] = '0;
            end
        end
        next_slot++;
        if (next_slot >= len)
            next_slot = 0;
        if (fill_level < len)
            fill_level++;
        emits = (fill_level >= len);
        for (int c = 0; c < CHANNELS; c++) begin
            if (run_cnt[c] != 0) begin
                res.avg[c] = DATA_W'(run_sum[c] / run_cnt[c]) & chan_mask(c);
                res.ok[c]  = 1'b1;
            end else begin
                res.avg[c] = '0;
                res.ok[c]  = 1'b0;
            end
        end
    endtask

    function automatic void clear_window();
        for (int c = 0; c < CHANNELS; c++) begin
            run_sum[c] = 0;
            run_cnt[c] = 0;
        end
        fill_level = 0;
        next_slot  = 0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0d] mismatch on %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
        errors++;
    endtask

    // Offers one record, after a random gap while idle_on is set, and keeps valid high until it is taken.
    task automatic send_record(input t_rec r);
        int   gap;
        bit   emits;
        t_avg res;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_weight_hundredths = r.val[0];
        i_fat_hundredths    = r.val[1][NARROW_W-1:0];
        i_muscle_hundredths = r.val[2][NARROW_W-1:0];
        i_water_hundredths  = r.val[3][NARROW_W-1:0];
        i_weight_present    = r.pres[0];
        i_fat_present       = r.pres[1];
        i_muscle_present    = r.pres[2];
        i_water_present     = r.pres[3];
        i_in_valid          = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
        slide_window(r, emits, res);
        if (emits)
            averages_due.push_back(res);
    endtask

    task automatic wait_for_averages();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (averages_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Only written while idle: all averages in, then a margin for records still in flight.
    task automatic write_window_length(input logic [LEN_W-1:0] len);
        wait_for_averages();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_window_length = len;
        i_cfg_valid         = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        win_len = len;
        clear_window();
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_default_window();
        repeat (7)
            send_record(make_rec(16'hFFFF, 16'h3FFF, 16'h3FFF, 16'h3FFF, 4'hF));
        send_record(make_rec(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hF));
        send_record(make_rec(16'h5A5A, 16'h2A2A, 16'h1555, 16'h3FFF, 4'h0));
    endtask

    // A length of zero behaves as a window of one record.
    task automatic test_zero_length();
        write_window_length(6'd0);
        send_record(make_rec(16'd12345, 16'd10000, 16'd0, 16'd7, 4'b1011));
        send_record(make_rec(16'hFFFF, 16'h3FFF, 16'h3FFF, 16'h3FFF, 4'b0000));
        send_record(make_rec(16'h8001, 16'h2001, 16'h1FFE, 16'h0001, 4'b1111));
    endtask

    task automatic test_missing_and_clear();
        write_window_length(6'd2);
        send_record(make_rec(16'd1234, 16'd99, 16'd99, 16'd99, 4'b0001));
        send_record(make_rec(16'd4321, 16'd5000, 16'd99, 16'd99, 4'b0010));
        send_record(make_rec(16'd1, 16'd1, 16'd1, 16'd1, 4'b0000));
        send_record(make_rec(16'd3, 16'd2, 16'd3, 16'd4, 4'b1111));
        send_record(make_rec(16'd4, 16'd1, 16'd6, 16'd9, 4'b1111));
        send_record(make_rec(16'd100, 16'd200, 16'd300, 16'd400, 4'b1111));
        // Rewriting the same length must still empty the window.
        write_window_length(6'd2);
        send_record(make_rec(16'd10, 16'd20, 16'd30, 16'd40, 4'b1111));
        send_record(make_rec(16'd11, 16'd21, 16'd31, 16'd41, 4'b0101));
    endtask

    // The receiver stops for a long stretch while records keep coming, so the
    // block fills up and must stall its input.
    task automatic test_output_hold();
        write_window_length(6'd1);
        idle_on = 1'b0;
        @(posedge i_clk);
        hold_left = 400;
        repeat (30)
            send_record(rand_rec(80));
        idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        write_window_length(6'd4);
        repeat (20)
            send_record(rand_rec(70));
        wait_for_averages();
        repeat (20)
            send_record(rand_rec(70));
    endtask

    task automatic test_random_windows();
        logic [LEN_W-1:0] lens [12] = '{6'd32, 6'd1, 6'd63, 6'd33, 6'd5, 6'd16,
                                        6'd0, 6'd2, 6'd31, 6'd9, 6'd48, 6'd3};
        int               pcts [6]  = '{90, 50, 100, 10, 0, 75};
        int               count;
        for (int k = 0; k < 12; k++) begin
            write_window_length(lens[k]);
            idle_on = (k != 4);
            count = active_length() + $urandom_range(20, 40);
            repeat (count)
                send_record(rand_rec(pcts[k % 6]));
        end
        idle_on = 1'b1;
    endtask

    // Receiver: a long hold-off when asked, otherwise a random stall per transaction while idle_on is set.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else if (stall_left != 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_avg got;
        t_avg want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.avg[0] = o_weight_avg;
            got.avg[1] = {2'b00, o_fat_avg};
            got.avg[2] = {2'b00, o_muscle_avg};
            got.avg[3] = {2'b00, o_water_avg};
            got.ok     = {o_water_avg_ok, o_muscle_avg_ok, o_fat_avg_ok, o_weight_avg_ok};
            averages_seen++;
            if (averages_due.size() == 0) begin
                report_mismatch("result with nothing pending", got.avg[0], 0);
            end else begin
                want = averages_due.pop_front();
                for (int c = 0; c < CHANNELS; c++) begin
                    if (got.avg[c] !== want.avg[c])
                        report_mismatch({ch_name[c], "_avg"}, got.avg[c], want.avg[c]);
                    if (got.ok[c] !== want.ok[c])
                        report_mismatch({ch_name[c], "_avg_ok"}, got.ok[c], want.ok[c]);
                end
            end
            stall_left = idle_on ? $urandom_range(0, 5) : 0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_window_length = '0;
        i_in_valid          = 1'b0;
        i_weight_hundredths = '0;
        i_weight_present    = 1'b0;
        i_fat_hundredths    = '0;
        i_fat_present       = 1'b0;
        i_muscle_hundredths = '0;
        i_muscle_present    = 1'b0;
        i_water_hundredths  = '0;
        i_water_present     = 1'b0;
        i_out_ready         = 1'b0;
        errors        = 0;
        items_sent    = 0;
        averages_seen = 0;
        settings_used = 1;
        cycle_count   = 0;
        hold_left     = 0;
        stall_left    = 0;
        idle_on       = 1'b1;
        win_len       = DEFAULT_WINDOW;
        for (int s = 0; s < MAX_WINDOW; s++) begin
            ring_val[s]  = '0;
            ring_pres[s] = '0;
        end
        clear_window();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_window();
        test_zero_length();
        test_missing_and_clear();
        test_output_hold();
        test_sender_pause();
        test_random_windows();

        wait_for_averages();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d records and checked %0d averages across %0d window settings,",
                 items_sent, averages_seen, settings_used);
        $display("including missing channels, full-scale values, window clears and stalls.");
        if (errors == 0 && averages_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
